/* hw/rtl/clipped_triangle_prism_volume_core_defines.svh */
// assertion macros for the clipped triangle prism volume core
// no dependencies; included by the top level of the block
`ifndef CLIPPED_TRIANGLE_PRISM_VOLUME_CORE_DEFINES_SVH
`define CLIPPED_TRIANGLE_PRISM_VOLUME_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CTPV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ctpv assertion failed");
`define CTPV_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ctpv forbidden condition seen");
`else
`define CTPV_ASSERT(lbl, clk, rst_n, prop)
`define CTPV_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* hw/rtl/ctpv_pkg.sv */
// shared types, widths and helpers of the clipped triangle prism volume core
// no dependencies; imported by ctpv_div and the top level
package ctpv_pkg;

  localparam int CoordW    = 32;
  localparam int DenW      = 32;              // edge span and clip depth
  localparam int CrossW    = 65;              // magnitude of the yz cross product
  localparam int HeightW   = 34;              // sum of up to three depths
  localparam int DivQW     = CrossW;          // quotient bits, one per divider stage
  localparam int DivNumW   = DenW + DivQW;    // dividend bits
  localparam int ChW       = CrossW + HeightW;
  localparam int VolShift  = 25;              // power of two part of 6 * 2^24
  localparam int Div3W     = ChW - VolShift;
  localparam int Div3Per   = 8;
  localparam int Div3Stages = (Div3W + Div3Per - 1) / Div3Per;
  localparam int OutW      = 64;

  typedef enum logic [1:0] {
    CsNone,
    CsOne,
    CsTwo,
    CsAll
  } case_e;

  typedef struct packed {
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v1_z;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v2_z;
    logic signed [CoordW-1:0] v3_x;
    logic signed [CoordW-1:0] v3_y;
    logic signed [CoordW-1:0] v3_z;
  } tri_t;

  typedef struct packed {
    logic signed [OutW-1:0] area_behind;
    logic signed [OutW-1:0] volume_behind;
    logic                   saturated;
  } res_t;

  // values carried alongside the dividers
  typedef struct packed {
    case_e              cs;
    logic               neg;
    logic [DenW-1:0]    a;
    logic [DenW-1:0]    dr;
    logic [CrossW-1:0]  c;
    logic [ChW-1:0]     ch;
  } side_t;

  typedef struct packed {
    logic [OutW-1:0] val;
    logic            flag;
  } sat_t;

  localparam logic [OutW-1:0] SatMin = {1'b1, {(OutW-1){1'b0}}};
  localparam logic [OutW-1:0] SatMax = {1'b0, {(OutW-1){1'b1}}};

  function automatic sat_t sat_mag(input logic [Div3W-1:0] mag, input logic neg);
    sat_t r;
    r.flag = 1'b0;
    if (mag < Div3W'(SatMin)) begin
      r.val = neg ? (OutW'(0) - mag[OutW-1:0]) : mag[OutW-1:0];
    end else if (neg && (mag == Div3W'(SatMin))) begin
      r.val = SatMin;
    end else begin
      r.flag = 1'b1;
      r.val  = neg ? SatMin : SatMax;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/clipped_triangle_prism_volume_core.sv */
// top level of the clipped triangle prism volume core
// depends on ctpv_pkg, ctpv_div and clipped_triangle_prism_volume_core_defines.svh
`include "clipped_triangle_prism_volume_core_defines.svh"

// Takes one triangle request per clock and returns the signed yz area and
// volume of the part beyond the plane x = front position, with a saturation
// flag. busy_o is always low: every cycle with start_i high is a new
// request, and done_o marks each result for exactly one cycle. The pipeline
// is made of the two chained 65-stage restoring dividers (one quotient bit
// per stage) for the edge intersections, plus six stages of setup and cross
// product, two stages of multiply between the dividers, four stages of
// volume numerator, ten stages of divide by three (up to eight bits each)
// and the output register. The front position register may be written only
// while no request is in flight.
module clipped_triangle_prism_volume_core import ctpv_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  tri_t                     req_i,
  output logic                     done_o,
  output res_t                     res_o,
  input  logic                     wr_en_i,
  input  logic signed [CoordW-1:0] wr_data_i
);

  localparam int Latency = 6 + 2 * DivQW + 2 + 4 + Div3Stages + 1;
  localparam logic [2:0] Three = 3'd3;

  // never stalls
  assign busy_o = 1'b0;

  // front position register
  logic signed [CoordW-1:0] front_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else if (wr_en_i) begin
      front_q <= wr_data_i;
    end
  end

  // ---------------------------------------------------------------- request register
  logic in_valid_q;
  tri_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= req_i;
  end

  // ---------------------------------------------------------------- stage 1: classify
  logic signed [CoordW-1:0] xv [3];
  logic signed [CoordW:0]   ev [3];     // depth of each vertex beyond the front
  logic [2:0]               beyond;
  logic [1:0]               nb;
  logic [1:0]               pi, qi, ri;
  case_e                    cs_d;
  logic signed [CoordW:0]   xp, xq, xr, dpq, dpr, du1, dv1, du2, dv2;
  logic signed [HeightW-1:0] h_full;
  logic [DenW-1:0]          a_d, dq_d, dr_d;
  logic [DenW-1:0]          m_d [4];
  logic                     sg1_d, sg2_d;

  always_comb begin
    xv[0] = in_q.v1_x;
    xv[1] = in_q.v2_x;
    xv[2] = in_q.v3_x;
    for (int i = 0; i < 3; i++) begin
      ev[i]     = {xv[i][CoordW-1], xv[i]} - {front_q[CoordW-1], front_q};
      beyond[i] = xv[i] > front_q;
    end
    nb = 2'(beyond[0]) + 2'(beyond[1]) + 2'(beyond[2]);
    unique case (nb)
      2'd0: cs_d = CsNone;
      2'd1: cs_d = CsOne;
      2'd2: cs_d = CsTwo;
      default: cs_d = CsAll;
    endcase
    // the odd vertex: alone beyond, or alone in front
    pi = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (beyond[i] == (nb == 2'd1)) pi = 2'(i);
    end
    unique case (pi)
      2'd1: begin qi = 2'd2; ri = 2'd0; end
      2'd2: begin qi = 2'd0; ri = 2'd1; end
      default: begin qi = 2'd1; ri = 2'd2; end
    endcase
    xp  = {xv[pi][CoordW-1], xv[pi]};
    xq  = {xv[qi][CoordW-1], xv[qi]};
    xr  = {xv[ri][CoordW-1], xv[ri]};
    dpq = xp - xq;
    dpr = xp - xr;
    if (cs_d == CsTwo) begin
      a_d  = DenW'(-ev[pi]);
      dq_d = DenW'(-dpq);
      dr_d = DenW'(-dpr);
    end else begin
      a_d  = DenW'(ev[pi]);
      dq_d = DenW'(dpq);
      dr_d = DenW'(dpr);
    end
    if (cs_d == CsAll) begin
      h_full = HeightW'(ev[0]) + HeightW'(ev[1]) + HeightW'(ev[2]);
    end else begin
      h_full = HeightW'(ev[qi]) + HeightW'(ev[ri]);
    end
    // cross product operands as magnitude and sign
    du1 = {in_q.v2_y[CoordW-1], in_q.v2_y} - {in_q.v1_y[CoordW-1], in_q.v1_y};
    dv1 = {in_q.v3_z[CoordW-1], in_q.v3_z} - {in_q.v1_z[CoordW-1], in_q.v1_z};
    du2 = {in_q.v3_y[CoordW-1], in_q.v3_y} - {in_q.v1_y[CoordW-1], in_q.v1_y};
    dv2 = {in_q.v2_z[CoordW-1], in_q.v2_z} - {in_q.v1_z[CoordW-1], in_q.v1_z};
    m_d[0] = DenW'(du1[CoordW] ? -du1 : du1);
    m_d[1] = DenW'(dv1[CoordW] ? -dv1 : dv1);
    m_d[2] = DenW'(du2[CoordW] ? -du2 : du2);
    m_d[3] = DenW'(dv2[CoordW] ? -dv2 : dv2);
    sg1_d  = du1[CoordW] ^ dv1[CoordW];
    sg2_d  = du2[CoordW] ^ dv2[CoordW];
  end

  logic                s1_valid_q;
  case_e               s1_cs_q;
  logic [DenW-1:0]     s1_a_q, s1_dq_q, s1_dr_q;
  logic [HeightW-1:0]  s1_h_q;
  logic [DenW-1:0]     s1_m_q [4];
  logic                s1_sg1_q, s1_sg2_q;

  always_ff @(posedge clk_i) begin
    s1_cs_q  <= cs_d;
    s1_a_q   <= a_d;
    s1_dq_q  <= dq_d;
    s1_dr_q  <= dr_d;
    s1_h_q   <= h_full;
    s1_m_q   <= m_d;
    s1_sg1_q <= sg1_d;
    s1_sg2_q <= sg2_d;
  end

  // ---------------------------------------------------------------- stage 2: cross products
  logic                s2_valid_q;
  case_e               s2_cs_q;
  logic [DenW-1:0]     s2_a_q, s2_dq_q, s2_dr_q;
  logic [HeightW-1:0]  s2_h_q;
  logic [2*DenW-1:0]   s2_p1_q, s2_p2_q;
  logic                s2_sg1_q, s2_sg2_q;

  always_ff @(posedge clk_i) begin
    s2_cs_q  <= s1_cs_q;
    s2_a_q   <= s1_a_q;
    s2_dq_q  <= s1_dq_q;
    s2_dr_q  <= s1_dr_q;
    s2_h_q   <= s1_h_q;
    s2_p1_q  <= s1_m_q[0] * s1_m_q[1];
    s2_p2_q  <= s1_m_q[2] * s1_m_q[3];
    s2_sg1_q <= s1_sg1_q;
    s2_sg2_q <= s1_sg2_q;
  end

  // ---------------------------------------------------------------- stage 3: magnitude and sign
  logic [CrossW:0] sp1, sp2, kr, kmag;

  always_comb begin
    sp1  = s2_sg1_q ? ((CrossW+1)'(0) - {2'b0, s2_p1_q}) : {2'b0, s2_p1_q};
    sp2  = s2_sg2_q ? ((CrossW+1)'(0) - {2'b0, s2_p2_q}) : {2'b0, s2_p2_q};
    kr   = sp1 - sp2;
    kmag = kr[CrossW] ? ((CrossW+1)'(0) - kr) : kr;
  end

  logic                s3_valid_q;
  case_e               s3_cs_q;
  logic                s3_neg_q;
  logic [CrossW-1:0]   s3_c_q;
  logic [DenW-1:0]     s3_a_q, s3_dq_q, s3_dr_q;
  logic [HeightW-1:0]  s3_h_q;

  always_ff @(posedge clk_i) begin
    s3_cs_q  <= s2_cs_q;
    // positive cross product gives a negative result
    s3_neg_q <= !kr[CrossW] && (kr != '0);
    s3_c_q   <= kmag[CrossW-1:0];
    s3_a_q   <= s2_a_q;
    s3_dq_q  <= s2_dq_q;
    s3_dr_q  <= s2_dr_q;
    s3_h_q   <= s2_h_q;
  end

  // ---------------------------------------------------------------- stage 4: partial products
  localparam int CHiW = CrossW - DenW;

  logic                      s4_valid_q;
  case_e                     s4_cs_q;
  logic                      s4_neg_q;
  logic [CrossW-1:0]         s4_c_q;
  logic [DenW-1:0]           s4_a_q, s4_dq_q, s4_dr_q;
  logic [2*DenW-1:0]         s4_pa_lo_q;
  logic [CrossW-1:0]         s4_pa_hi_q;
  logic [DenW+HeightW-1:0]   s4_ph_lo_q;
  logic [CHiW+HeightW-1:0]   s4_ph_hi_q;

  always_ff @(posedge clk_i) begin
    s4_cs_q    <= s3_cs_q;
    s4_neg_q   <= s3_neg_q;
    s4_c_q     <= s3_c_q;
    s4_a_q     <= s3_a_q;
    s4_dq_q    <= s3_dq_q;
    s4_dr_q    <= s3_dr_q;
    s4_pa_lo_q <= s3_c_q[DenW-1:0] * s3_a_q;
    s4_pa_hi_q <= s3_c_q[CrossW-1:DenW] * s3_a_q;
    s4_ph_lo_q <= s3_c_q[DenW-1:0] * s3_h_q;
    s4_ph_hi_q <= s3_c_q[CrossW-1:DenW] * s3_h_q;
  end

  // ---------------------------------------------------------------- stage 5: sums, divider feed
  logic                s5_valid_q;
  logic [DivNumW-1:0]  s5_num_q;
  logic [DenW-1:0]     s5_den_q;
  side_t               s5_side_q;

  always_ff @(posedge clk_i) begin
    s5_num_q       <= DivNumW'(s4_pa_lo_q) + {s4_pa_hi_q, {DenW{1'b0}}};
    s5_den_q       <= s4_dq_q;
    s5_side_q.cs   <= s4_cs_q;
    s5_side_q.neg  <= s4_neg_q;
    s5_side_q.a    <= s4_a_q;
    s5_side_q.dr   <= s4_dr_q;
    s5_side_q.c    <= s4_c_q;
    s5_side_q.ch   <= ChW'(s4_ph_lo_q) + {s4_ph_hi_q, {DenW{1'b0}}};
  end

  // ---------------------------------------------------------------- first intersection: c*a/dq
  logic              d1_valid;
  logic [DivQW-1:0]  d1_quot;
  side_t             d1_side;

  ctpv_div u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s5_valid_q),
    .num_i   (s5_num_q),
    .den_i   (s5_den_q),
    .side_i  (s5_side_q),
    .valid_o (d1_valid),
    .quot_o  (d1_quot),
    .side_o  (d1_side)
  );

  // ---------------------------------------------------------------- stages 6, 7: times a again
  logic               s6_valid_q;
  side_t              s6_side_q;
  logic [2*DenW-1:0]  s6_lo_q;
  logic [CrossW-1:0]  s6_hi_q;

  always_ff @(posedge clk_i) begin
    s6_side_q <= d1_side;
    s6_lo_q   <= d1_quot[DenW-1:0] * d1_side.a;
    s6_hi_q   <= d1_quot[DivQW-1:DenW] * d1_side.a;
  end

  logic                s7_valid_q;
  side_t               s7_side_q;
  logic [DivNumW-1:0]  s7_num_q;

  always_ff @(posedge clk_i) begin
    s7_side_q <= s6_side_q;
    s7_num_q  <= DivNumW'(s6_lo_q) + {s6_hi_q, {DenW{1'b0}}};
  end

  // ---------------------------------------------------------------- second intersection: /dr
  logic              d2_valid;
  logic [DivQW-1:0]  d2_quot;
  side_t             d2_side;

  ctpv_div u_div_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_valid_q),
    .num_i   (s7_num_q),
    .den_i   (s7_side_q.dr),
    .side_i  (s7_side_q),
    .valid_o (d2_valid),
    .quot_o  (d2_quot),
    .side_o  (d2_side)
  );

  // ---------------------------------------------------------------- stage 8: clipped part
  logic [CrossW-1:0] rest, xsel;
  logic [OutW-1:0]   area_d;

  always_comb begin
    rest = d2_side.c - d2_quot;
    xsel = (d2_side.cs == CsOne) ? d2_quot : rest;
    unique case (d2_side.cs)
      CsNone:       area_d = '0;
      CsAll:        area_d = d2_side.c[CrossW-1:1];
      CsOne, CsTwo: area_d = xsel[CrossW-1:1];
    endcase
  end

  logic               s8_valid_q;
  case_e              s8_cs_q;
  logic               s8_neg_q;
  logic [DenW-1:0]    s8_a_q;
  logic [ChW-1:0]     s8_ch_q;
  logic [CrossW-1:0]  s8_x_q;
  logic [OutW-1:0]    s8_area_q;

  always_ff @(posedge clk_i) begin
    s8_cs_q   <= d2_side.cs;
    s8_neg_q  <= d2_side.neg;
    s8_a_q    <= d2_side.a;
    s8_ch_q   <= d2_side.ch;
    s8_x_q    <= xsel;
    s8_area_q <= area_d;
  end

  // ---------------------------------------------------------------- stages 9, 10: x times a
  logic               s9_valid_q;
  case_e              s9_cs_q;
  logic               s9_neg_q;
  logic [ChW-1:0]     s9_ch_q;
  logic [OutW-1:0]    s9_area_q;
  logic [2*DenW-1:0]  s9_lo_q;
  logic [CrossW-1:0]  s9_hi_q;

  always_ff @(posedge clk_i) begin
    s9_cs_q   <= s8_cs_q;
    s9_neg_q  <= s8_neg_q;
    s9_ch_q   <= s8_ch_q;
    s9_area_q <= s8_area_q;
    s9_lo_q   <= s8_x_q[DenW-1:0] * s8_a_q;
    s9_hi_q   <= s8_x_q[CrossW-1:DenW] * s8_a_q;
  end

  logic                s10_valid_q;
  case_e               s10_cs_q;
  logic                s10_neg_q;
  logic [ChW-1:0]      s10_ch_q;
  logic [OutW-1:0]     s10_area_q;
  logic [DivNumW-1:0]  s10_m_q;

  always_ff @(posedge clk_i) begin
    s10_cs_q   <= s9_cs_q;
    s10_neg_q  <= s9_neg_q;
    s10_ch_q   <= s9_ch_q;
    s10_area_q <= s9_area_q;
    s10_m_q    <= DivNumW'(s9_lo_q) + {s9_hi_q, {DenW{1'b0}}};
  end

  // ---------------------------------------------------------------- stage 11: volume numerator
  logic [ChW:0]    vdiff;
  logic [ChW-1:0]  vnum;

  always_comb begin
    vdiff = {1'b0, s10_ch_q} - (ChW+1)'(s10_m_q);
    unique case (s10_cs_q)
      CsNone: vnum = '0;
      CsOne:  vnum = ChW'(s10_m_q);
      // truncation can push the two-beyond numerator below zero
      CsTwo:  vnum = vdiff[ChW] ? '0 : vdiff[ChW-1:0];
      CsAll:  vnum = s10_ch_q;
    endcase
  end

  logic               s11_valid_q;
  logic               s11_neg_q;
  logic [OutW-1:0]    s11_area_q;
  logic [Div3W-1:0]   s11_v_q;

  always_ff @(posedge clk_i) begin
    s11_neg_q  <= s10_neg_q;
    s11_area_q <= s10_area_q;
    s11_v_q    <= vnum[ChW-1:VolShift];   // the 2^25 part of the divisor
  end

  // ---------------------------------------------------------------- divide by three
  localparam int W3 = Div3W + 2;

  function automatic logic [W3-1:0] div3_step(input logic [W3-1:0] w);
    logic [2:0] t;
    logic       ge;
    logic [2:0] r;
    t  = w[W3-1:W3-3];
    ge = t >= Three;
    r  = ge ? (t - Three) : t;
    return {r[1:0], w[W3-4:0], ge};
  endfunction

  logic [Div3Stages-1:0] d3_valid_q;
  logic [W3-1:0]         d3_w_q    [Div3Stages];
  logic                  d3_neg_q  [Div3Stages];
  logic [OutW-1:0]       d3_area_q [Div3Stages];

  for (genvar s = 0; s < Div3Stages; s++) begin : g_div3
    localparam int Steps = (Div3W - s * Div3Per) < Div3Per ?
                           (Div3W - s * Div3Per) : Div3Per;
    logic            v_in;
    logic [W3-1:0]   w_in;
    logic            n_in;
    logic [OutW-1:0] ar_in;
    logic [W3-1:0]   w_d;

    if (s == 0) begin : g_first
      assign v_in  = s11_valid_q;
      assign w_in  = {2'b00, s11_v_q};
      assign n_in  = s11_neg_q;
      assign ar_in = s11_area_q;
    end else begin : g_next
      assign v_in  = d3_valid_q[s-1];
      assign w_in  = d3_w_q[s-1];
      assign n_in  = d3_neg_q[s-1];
      assign ar_in = d3_area_q[s-1];
    end

    always_comb begin
      w_d = w_in;
      for (int j = 0; j < Steps; j++) begin
        w_d = div3_step(w_d);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d3_valid_q[s] <= 1'b0;
      end else begin
        d3_valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      d3_w_q[s]    <= w_d;
      d3_neg_q[s]  <= n_in;
      d3_area_q[s] <= ar_in;
    end
  end

  // ---------------------------------------------------------------- saturation and output
  sat_t sat_area, sat_vol;

  always_comb begin
    sat_area = sat_mag(Div3W'(d3_area_q[Div3Stages-1]), d3_neg_q[Div3Stages-1]);
    sat_vol  = sat_mag(d3_w_q[Div3Stages-1][Div3W-1:0], d3_neg_q[Div3Stages-1]);
  end

  logic done_q;
  res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.area_behind   <= $signed(sat_area.val);
    res_q.volume_behind <= $signed(sat_vol.val);
    res_q.saturated     <= sat_area.flag | sat_vol.flag;
  end

  // valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      s8_valid_q  <= 1'b0;
      s9_valid_q  <= 1'b0;
      s10_valid_q <= 1'b0;
      s11_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      s1_valid_q  <= in_valid_q;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= d1_valid;
      s7_valid_q  <= s6_valid_q;
      s8_valid_q  <= d2_valid;
      s9_valid_q  <= s8_valid_q;
      s10_valid_q <= s9_valid_q;
      s11_valid_q <= s10_valid_q;
      done_q      <= d3_valid_q[Div3Stages-1];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // ---------------------------------------------------------------- assertions
  // a clamped result sits on one of the two limits
  logic sat_at_limit;

  assign sat_at_limit = (res_o.area_behind == $signed(SatMin)) ||
                        (res_o.area_behind == $signed(SatMax)) ||
                        (res_o.volume_behind == $signed(SatMin)) ||
                        (res_o.volume_behind == $signed(SatMax));

  `CTPV_ASSERT(a_req_gives_result, clk_i, rst_ni, (start_i && !busy_o) |-> ##Latency done_o)
  `CTPV_ASSERT(a_result_has_req, clk_i, rst_ni, done_o |-> $past(start_i && !busy_o, Latency))
  `CTPV_ASSERT_NEVER(a_sat_off_limit, clk_i, rst_ni, done_o && res_o.saturated && !sat_at_limit)

endmodule

/* hw/rtl/ctpv_div.sv */
// pipelined restoring divider, one quotient bit per register stage
// depends on ctpv_pkg for widths and the side band type
module ctpv_div import ctpv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [DivNumW-1:0]  num_i,
  input  logic [DenW-1:0]     den_i,
  input  side_t               side_i,
  output logic                valid_o,
  output logic [DivQW-1:0]    quot_o,
  output side_t               side_o
);

  logic [DivQW-1:0]   valid_q;
  logic [DivNumW-1:0] work_q [DivQW];
  logic [DenW-1:0]    den_q  [DivQW];
  side_t              side_q [DivQW];

  for (genvar s = 0; s < DivQW; s++) begin : g_stage
    logic               v_in;
    logic [DivNumW-1:0] w_in;
    logic [DenW-1:0]    d_in;
    side_t              sd_in;
    logic [DenW:0]      trial;
    logic [DenW:0]      diff;
    logic               ge;
    logic [DivNumW-1:0] work_d;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign w_in  = num_i;
      assign d_in  = den_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = valid_q[s-1];
      assign w_in  = work_q[s-1];
      assign d_in  = den_q[s-1];
      assign sd_in = side_q[s-1];
    end

    // partial remainder with the next dividend bit shifted in
    assign trial  = w_in[DivNumW-1:DivQW-1];
    assign diff   = trial - {1'b0, d_in};
    assign ge     = trial >= {1'b0, d_in};
    assign work_d = {ge ? diff[DenW-1:0] : trial[DenW-1:0], w_in[DivQW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      work_q[s] <= work_d;
      den_q[s]  <= d_in;
      side_q[s] <= sd_in;
    end
  end

  assign valid_o = valid_q[DivQW-1];
  assign quot_o  = work_q[DivQW-1][DivQW-1:0];
  assign side_o  = side_q[DivQW-1];

endmodule
